>>> rtl/bcd_add_sub_multiply_assert.svh
// assertion macros for the decimal add, subtract and multiply unit
`ifndef BCD_ADD_SUB_MULTIPLY_ASSERT_SVH
`define BCD_ADD_SUB_MULTIPLY_ASSERT_SVH

// condition implies consequence in the same cycle
`define BSM_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("bsm same-cycle check failed");

// condition implies consequence in the next cycle
`define BSM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("bsm next-cycle check failed");

`endif

>>> rtl/bsm_pkg.sv
// shared types and constants for the decimal add, subtract and multiply unit
package bsm_pkg;

    localparam int BSM_DIGITS = 16;
    localparam int BSM_WORD_W = 64;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_NEGATIVE = 2'd2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [BSM_WORD_W-1:0] operand_a;
        logic [BSM_WORD_W-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [BSM_WORD_W-1:0] result_bcd;
        logic [1:0]            status;
    } t_rsp;

    typedef struct packed {
        logic clr;
        logic en;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_SETTLE,
        S_DONE
    } t_state;

endpackage

>>> rtl/bsm_cell.sv
// one decimal digit cell: holds a digit and a signed carry for its upper neighbour
module bsm_cell (
    input  logic              i_clk,
    input  bsm_pkg::t_cell_ctl i_ctl,
    input  logic [3:0]        i_d_sh,
    input  logic signed [5:0] i_c_sh,
    input  logic signed [5:0] i_c_nb,
    input  logic [3:0]        i_x,
    input  logic signed [4:0] i_m,
    output logic [3:0]        o_d,
    output logic signed [5:0] o_c
);
    import bsm_pkg::*;

    logic [3:0]        r_d, n_d;
    logic signed [5:0] r_c, n_c;
    logic [3:0]        d_base;
    logic signed [5:0] c_base;
    logic signed [9:0] prod;
    logic signed [9:0] s;
    logic [8:0]        u;
    logic [15:0]       qm;
    logic [4:0]        q;

    always_comb begin
        d_base = i_ctl.shift ? i_d_sh : r_d;
        c_base = i_ctl.shift ? i_c_sh : i_c_nb;
        prod   = $signed({6'd0, i_x}) * $signed({{5{i_m[4]}}, i_m});
        s      = $signed({6'd0, d_base}) + $signed({{4{c_base[5]}}, c_base}) + prod;
        // offset keeps the floor division on a non-negative value
        u      = 9'(s + 10'sd20);
        qm     = 16'(u) * 16'd205;
        q      = qm[15:11];
        n_d    = 4'(u - 9'(q) * 9'd10);
        n_c    = $signed(6'(q) - 6'd2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_d <= '0;
            r_c <= '0;
        end else if (i_ctl.en) begin
            r_d <= n_d;
            r_c <= n_c;
        end
    end

    assign o_d = r_d;
    assign o_c = r_c;
endmodule

>>> rtl/bcd_add_sub_multiply.sv
// top level: decimal add, subtract and multiply over a row of digit cells
//
//  channel | direction | handshake         | payload
//  request | in        | i_valid / o_ready | i_req (cmd, operand_a, operand_b)
//  result  | out       | o_valid / i_ready | o_rsp (result_bcd, status)
//
// add and subtract take a step that loads a and a step that adds or subtracts b,
// multiply takes a step per multiplier digit, then the settle state runs while carries
// ripple along the cell row until it sees them all clear, then the done state loads
// the result register once it is free.
// one request at a time; a new request is taken while a result waits in the register.
// reset is synchronous; a stalled result holds the unit in its final state.
module bcd_add_sub_multiply #(
    parameter int DIGITS = bsm_pkg::BSM_DIGITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bsm_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output bsm_pkg::t_rsp o_rsp
);
    import bsm_pkg::*;

    localparam int KW = $clog2(DIGITS + 2);

    t_state            r_state, n_state;
    logic [KW-1:0]     r_k;
    logic [1:0]        r_cmd;
    logic [4*DIGITS-1:0] r_a, r_b;
    logic              r_bad, r_ovf;
    logic signed [7:0] r_top;
    logic              r_out_valid;
    t_rsp              r_rsp, n_rsp;

    t_cell_ctl         ctl;
    logic signed [4:0] m;
    logic [3:0]        x [DIGITS];
    logic [3:0]        d [DIGITS];
    logic signed [5:0] c [DIGITS];
    logic [3:0]        d_sh [DIGITS];
    logic signed [5:0] c_sh [DIGITS];
    logic signed [5:0] c_nb [DIGITS];
    logic [DIGITS-1:0] c_nz;
    logic signed [5:0] c_out2;
    logic              last_step;
    logic              accept;
    logic              load_out;

    assign accept    = i_valid && o_ready;
    assign last_step = (r_cmd == CMD_MUL) ? (r_k == KW'(DIGITS - 1)) : (r_k == KW'(1));
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++) begin : g_cell
            if (gi == 0) begin : g_lo
                assign d_sh[gi] = '0;
                assign c_nb[gi] = '0;
            end else begin : g_nb
                assign d_sh[gi] = d[gi-1];
                assign c_nb[gi] = c[gi-1];
            end
            if (gi < 2) begin : g_lo2
                assign c_sh[gi] = '0;
            end else begin : g_nb2
                assign c_sh[gi] = c[gi-2];
            end
            assign c_nz[gi] = (c[gi] != 6'sd0);

            bsm_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_d_sh (d_sh[gi]),
                .i_c_sh (c_sh[gi]),
                .i_c_nb (c_nb[gi]),
                .i_x    (x[gi]),
                .i_m    (m),
                .o_d    (d[gi]),
                .o_c    (c[gi])
            );
        end
        if (DIGITS > 1) begin : g_c2
            assign c_out2 = c[DIGITS-2];
        end else begin : g_c1
            assign c_out2 = '0;
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL}) ? S_STEP : S_DONE;
                end
            end
            S_STEP: begin
                if (last_step) n_state = S_SETTLE;
            end
            S_SETTLE: begin
                if (c_nz == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell control and operand selection
    always_comb begin
        ctl     = '0;
        m       = '0;
        o_ready = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            x[i] = '0;
        end
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                ctl.clr = 1'b1;
            end
            S_STEP: begin
                ctl.en = 1'b1;
                if (r_cmd == CMD_MUL) begin
                    // horner: shift one digit up, add a times the next multiplier digit
                    ctl.shift = 1'b1;
                    m = $signed({1'b0, r_b[4*DIGITS-1 -: 4]});
                    for (int i = 0; i < DIGITS; i++) begin
                        x[i] = r_a[4*i +: 4];
                    end
                end else if (r_k == '0) begin
                    m = 5'sd1;
                    for (int i = 0; i < DIGITS; i++) begin
                        x[i] = r_a[4*i +: 4];
                    end
                end else begin
                    m = (r_cmd == CMD_SUB) ? -5'sd1 : 5'sd1;
                    for (int i = 0; i < DIGITS; i++) begin
                        x[i] = r_b[4*i +: 4];
                    end
                end
            end
            S_SETTLE: begin
                ctl.en = (c_nz != '0);
            end
            S_DONE: begin
                ctl = '0;
            end
            default: ctl = '0;
        endcase
    end

    // result word from the settled cells
    always_comb begin
        n_rsp = '0;
        if (r_bad || r_ovf || r_top > 8'sd0) begin
            n_rsp.status = ST_OVERFLOW;
        end else if (r_top < 8'sd0) begin
            n_rsp.status = ST_NEGATIVE;
        end else begin
            n_rsp.status = ST_OK;
            for (int i = 0; i < DIGITS; i++) begin
                n_rsp.result_bcd[4*i +: 4] = d[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_bad       <= 1'b0;
            r_ovf       <= 1'b0;
            r_top       <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_k   <= '0;
                r_bad <= !(i_req.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL});
                r_ovf <= 1'b0;
                r_top <= '0;
            end else if (ctl.en) begin
                if (r_state == S_STEP) r_k <= r_k + KW'(1);
                if (ctl.shift) begin
                    // anything leaving the top cell in a shift pushes past DIGITS digits
                    if (d[DIGITS-1] != 4'd0 || c[DIGITS-1] != 6'sd0 || c_out2 != 6'sd0) begin
                        r_ovf <= 1'b1;
                    end
                end else begin
                    r_top <= r_top + 8'(c[DIGITS-1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req.cmd;
            r_a   <= i_req.operand_a[4*DIGITS-1:0];
            r_b   <= i_req.operand_b[4*DIGITS-1:0];
        end else if (r_state == S_STEP && r_cmd == CMD_MUL) begin
            r_b <= r_b << 4;
        end
        if (load_out) r_rsp <= n_rsp;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

`include "bcd_add_sub_multiply_assert.svh"

    `BSM_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_rsp.status != ST_OK, o_rsp.result_bcd == '0)
    `BSM_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_valid, o_rsp.status <= ST_NEGATIVE)
    `BSM_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, accept, !o_ready)
    `BSM_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, load_out, o_valid)

endmodule
